>>> hw/rtl/hst_pkg.sv
package hst_pkg;

  localparam int TIME_W = 32;
  localparam int CODE_W = 3;
  localparam int POS_W  = 4;
  localparam int KIND_W = 2;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [CODE_W-1:0] hall_code_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam logic [KIND_W-1:0] EV_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] EV_TICK    = 2'd1;
  localparam logic [KIND_W-1:0] EV_TIMEOUT = 2'd2;

  localparam time_t MAX_TIMEOUT_RESET = 32'd100000;
  localparam time_t RELOAD_FLOOR      = 32'd1000;

  localparam int   NUM_POS  = 12;
  localparam pos_t POS_LAST = POS_W'(NUM_POS - 1);

  // Codes that never occur on a healthy sensor set.
  localparam hall_code_t CODE_ALL_LOW  = 3'd0;
  localparam hall_code_t CODE_ALL_HIGH = 3'd7;

  localparam hall_code_t CW_SUCC  [8] = '{3'd0, 3'd5, 3'd3, 3'd1, 3'd6, 3'd4, 3'd2, 3'd0};
  localparam hall_code_t CCW_SUCC [8] = '{3'd0, 3'd3, 3'd6, 3'd2, 3'd5, 3'd1, 3'd4, 3'd0};
  localparam pos_t       POS_TABLE[8] = '{4'd0, 4'd0, 4'd8, 4'd10, 4'd4, 4'd2, 4'd6, 4'd0};

  typedef struct packed {
    logic [KIND_W-1:0]  event_kind;
    hall_code_t         hall_state;
    time_t              delay_us;
    pos_t               position;
    logic               moving_cw;
    logic               moving;
    time_t              timer_reload;
    logic signed [31:0] odometry;
    logic [31:0]        invalid_count;
  } result_t;

endpackage

>>> hw/rtl/hst_ifs.sv
interface hst_sample_if import hst_pkg::*; ();
  logic       valid;
  logic       ready;
  hall_code_t hall_code;
  time_t      now_us;

  modport source (output valid, hall_code, now_us, input ready);
  modport sink (input valid, hall_code, now_us, output ready);
endinterface

interface hst_result_if import hst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  event_kind;
  hall_code_t         hall_state;
  time_t              delay_us;
  pos_t               position;
  logic               moving_cw;
  logic               moving;
  time_t              timer_reload;
  logic signed [31:0] odometry;
  logic [31:0]        invalid_count;

  modport source (output valid, event_kind, hall_state, delay_us, position, moving_cw,
                  moving, timer_reload, odometry, invalid_count, input ready);
  modport sink (input valid, event_kind, hall_state, delay_us, position, moving_cw,
                moving, timer_reload, odometry, invalid_count, output ready);
endinterface

interface hst_cfg_if import hst_pkg::*; ();
  logic  valid;
  logic  ready;
  time_t data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> hw/rtl/hst_core.sv
module hst_core import hst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  hall_code_t code,
  input  time_t      now_us,
  input  time_t      max_timeout_us,
  output result_t    res
);

  logic        primed, primed_next;
  hall_code_t  prev_hall, prev_hall_next;
  time_t       last_tick, last_tick_next;
  time_t       wait_limit, wait_limit_next;
  logic [31:0] step_count, step_count_next;
  logic [31:0] bad_steps, bad_steps_next;
  logic        dir_cw, dir_cw_next;
  logic        is_moving, is_moving_next;

  time_t             elapsed;
  logic [TIME_W:0]   grown;
  time_t             lim;
  pos_t              pos_base;
  pos_t              pos;
  logic              legal_prev;
  logic              step_cw;
  logic              step_ccw;
  logic [KIND_W-1:0] kind;
  time_t             reload;

  assign elapsed  = now_us - last_tick;
  assign pos_base = POS_TABLE[code];
  // 1.5 times the elapsed time, one bit wider so it cannot overflow.
  assign grown    = {1'b0, elapsed} + {2'b00, elapsed[TIME_W-1:1]};
  assign lim      = (grown > {1'b0, max_timeout_us}) ? max_timeout_us : grown[TIME_W-1:0];

  assign legal_prev = (prev_hall != CODE_ALL_LOW) && (prev_hall != CODE_ALL_HIGH);
  assign step_cw    = legal_prev && (CW_SUCC[prev_hall] == code);
  assign step_ccw   = legal_prev && !step_cw && (CCW_SUCC[prev_hall] == code);

  always_comb begin
    primed_next     = primed;
    prev_hall_next  = prev_hall;
    last_tick_next  = last_tick;
    wait_limit_next = wait_limit;
    step_count_next = step_count;
    bad_steps_next  = bad_steps;
    dir_cw_next     = dir_cw;
    is_moving_next  = is_moving;
    kind            = EV_NONE;
    pos             = pos_base;
    reload          = '0;

    if (!primed) begin
      primed_next     = 1'b1;
      prev_hall_next  = code;
      wait_limit_next = max_timeout_us;
    end else if (code == prev_hall) begin
      if (elapsed > wait_limit) begin
        wait_limit_next = lim;
        reload          = (lim > RELOAD_FLOOR) ? lim : RELOAD_FLOOR;
        kind            = EV_TIMEOUT;
      end
    end else begin
      if (step_cw) begin
        step_count_next = step_count + 32'd1;
        pos             = (pos_base == '0) ? POS_LAST : pos_base - pos_t'(1);
      end else if (step_ccw) begin
        step_count_next = step_count - 32'd1;
        pos             = pos_base + pos_t'(1);
      end else if (bad_steps != '1) begin
        bad_steps_next = bad_steps + 32'd1;
      end
      prev_hall_next = code;
      last_tick_next = now_us;
      // A tick needs a legal step in the same direction as the one before.
      if ((step_cw || step_ccw) && (dir_cw == step_cw)) begin
        is_moving_next = 1'b1;
        kind           = EV_TICK;
      end else begin
        is_moving_next = 1'b0;
      end
      dir_cw_next = step_cw;
    end
  end

  always_comb begin
    res.event_kind    = kind;
    res.hall_state    = prev_hall_next;
    res.delay_us      = elapsed;
    res.position      = pos;
    res.moving_cw     = dir_cw_next;
    res.moving        = is_moving_next;
    res.timer_reload  = reload;
    res.odometry      = signed'(step_count_next);
    res.invalid_count = bad_steps_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed     <= 1'b0;
      prev_hall  <= '0;
      last_tick  <= '0;
      wait_limit <= '0;
      step_count <= '0;
      bad_steps  <= '0;
      dir_cw     <= 1'b1;
      is_moving  <= 1'b0;
    end else if (fire) begin
      primed     <= primed_next;
      prev_hall  <= prev_hall_next;
      last_tick  <= last_tick_next;
      wait_limit <= wait_limit_next;
      step_count <= step_count_next;
      bad_steps  <= bad_steps_next;
      dir_cw     <= dir_cw_next;
      is_moving  <= is_moving_next;
    end
  end

endmodule

>>> hw/rtl/hall_sensor_transition_tracker.sv
// Channel   Dir   Payload
// sample    in    hall_code[2:0], now_us[31:0]
// result    out   event_kind, hall_state, delay_us, position, moving_cw, moving,
//                 timer_reload, odometry, invalid_count
// cfg       in    data[31:0] (max_timeout_us), always ready
//
// One sample per cycle while results are taken; a sample passes the sample register and
// then the result register before its result is offered.
// The rate is set by the sample register feeding the decode into the result register.
// Reset clears the tracking state, empties both registers and loads max_timeout_us = 100000.
// A stalled result holds the result register; the sample register still takes one more beat.
module hall_sensor_transition_tracker import hst_pkg::*; (
  input logic          clk,
  input logic          rst,
  hst_sample_if.sink   sample,
  hst_result_if.source result,
  hst_cfg_if.sink      cfg
);

  time_t      max_timeout_us;
  logic       s1_valid;
  hall_code_t s1_code;
  time_t      s1_now;
  logic       advance;
  logic       fire;
  result_t    core_res;
  result_t    r;
  logic       r_valid;

  assign advance      = !r_valid || result.ready;
  assign fire         = s1_valid && advance;
  assign sample.ready = !s1_valid || advance;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_timeout_us <= MAX_TIMEOUT_RESET;
    end else if (cfg.valid) begin
      max_timeout_us <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_code <= sample.hall_code;
      s1_now  <= sample.now_us;
    end
  end

  hst_core u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .code           (s1_code),
    .now_us         (s1_now),
    .max_timeout_us (max_timeout_us),
    .res            (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (fire) begin
      r_valid <= 1'b1;
    end else if (result.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      r <= core_res;
    end
  end

  assign result.valid         = r_valid;
  assign result.event_kind    = r.event_kind;
  assign result.hall_state    = r.hall_state;
  assign result.delay_us      = r.delay_us;
  assign result.position      = r.position;
  assign result.moving_cw     = r.moving_cw;
  assign result.moving        = r.moving;
  assign result.timer_reload  = r.timer_reload;
  assign result.odometry      = r.odometry;
  assign result.invalid_count = r.invalid_count;

endmodule

>>> hw/rtl/hst_checker.sv
module hst_checker import hst_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              r_valid,
  input logic              r_ready,
  input logic [KIND_W-1:0] event_kind,
  input pos_t              position,
  input logic              moving,
  input time_t             timer_reload
);

  // A result beat waiting on the sink is not withdrawn.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid)
    else $error("result beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !r_valid)
    else $error("result valid right after reset");

  // Only a timeout carries a reload, and that reload is never zero.
  a_reload: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> ((event_kind == EV_TIMEOUT) == (timer_reload != '0)))
    else $error("timer reload does not match the event kind");

  a_tick_moving: assert property (@(posedge clk) disable iff (rst)
    r_valid && (event_kind == EV_TICK) |-> moving)
    else $error("tick reported without the moving flag");

  a_position: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> (position <= POS_LAST))
    else $error("position out of range");

endmodule

bind hall_sensor_transition_tracker hst_checker u_hst_checker (
  .clk          (clk),
  .rst          (rst),
  .r_valid      (result.valid),
  .r_ready      (result.ready),
  .event_kind   (result.event_kind),
  .position     (result.position),
  .moving       (result.moving),
  .timer_reload (result.timer_reload)
);
